@@ src/b2d_pkg.sv @@
// Package: widths, payload type and the double-dabble step for the decimal converter.
`default_nettype none
package b2d_pkg;

  localparam int VALUE_W        = 31;   // input value width
  localparam int DIGIT_W        = 6;    // ASCII digit field width
  localparam int NUM_DIG        = 10;   // decimal digits of the widest value
  localparam int BCD_W          = 4 * NUM_DIG;
  localparam int DD_STAGES      = 4;    // pipeline stages of the conversion
  localparam int DD_STEPS       = (VALUE_W + DD_STAGES - 1) / DD_STAGES;
  localparam int MAX_DIGITS_DEF = 10;

  localparam logic [DIGIT_W-1:0] ASCII_ZERO = 6'd48;

  // Conversion payload: BCD accumulator and the binary bits still to shift in.
  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
  } dd_t;

  // One double-dabble step: add 3 to every digit of 5 or more, then shift.
  function automatic dd_t dd_step(input dd_t d);
    dd_t r;
    r = d;
    for (int j = 0; j < NUM_DIG; j++) begin
      if (r.bcd[4*j +: 4] >= 4'd5) begin
        r.bcd[4*j +: 4] = r.bcd[4*j +: 4] + 4'd3;
      end
    end
    r.bcd = {r.bcd[BCD_W-2:0], r.bin[VALUE_W-1]};
    r.bin = {r.bin[VALUE_W-2:0], 1'b0};
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/b2d_if.sv @@
// Interfaces: input value channel and output digit channel.
`default_nettype none
interface b2d_in_if;
  import b2d_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  modport source (output valid, input ready, output value);
  modport sink   (input valid, output ready, input value);
endinterface

interface b2d_out_if;
  import b2d_pkg::*;
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit_char;
  logic               last_digit;
  modport source (output valid, input ready, output digit_char, output last_digit);
  modport sink   (input valid, output ready, input digit_char, input last_digit);
endinterface
`default_nettype wire

@@ src/b2d_dd_stage.sv @@
// Module: one registered stage of double-dabble shift steps.
`default_nettype none
module b2d_dd_stage #(
  parameter int STEPS = b2d_pkg::DD_STEPS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire b2d_pkg::dd_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output b2d_pkg::dd_t      out_data
);
  import b2d_pkg::*;

  logic valid_r;
  dd_t  data_r;
  dd_t  data_nxt;

  always_comb begin
    data_nxt = in_data;
    for (int s = 0; s < STEPS; s++) begin
      data_nxt = dd_step(data_nxt);
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/b2d_ser.sv @@
// Module: digit serialiser, most significant digit first, leading zeros dropped unless the value is cut to MAX_DIGITS.
`default_nettype none
module b2d_ser #(
  parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [b2d_pkg::BCD_W-1:0] in_bcd,
  b2d_out_if.source                    out_ch
);
  import b2d_pkg::*;

  localparam int KEEP  = (MAX_DIGITS < NUM_DIG) ? MAX_DIGITS : NUM_DIG;
  localparam int IDX_W = (KEEP > 1) ? $clog2(KEEP) : 1;

  logic                  busy_r;
  logic [IDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]      idx_nxt;
  logic [KEEP-1:0][3:0]  digs_r;
  logic                  last_w;
  logic                  load_w;
  int                    top;

  // Highest non-zero digit, clamped to the digits kept; zero gives the units digit.
  always_comb begin
    top = 0;
    for (int j = 0; j < NUM_DIG; j++) begin
      if (in_bcd[4*j +: 4] != 4'd0) begin
        top = j;
      end
    end
    idx_nxt = (top < KEEP - 1) ? IDX_W'(top) : IDX_W'(KEEP - 1);
  end

  assign last_w            = (idx_r == '0);
  assign in_ready          = !busy_r || (out_ch.ready && last_w);
  assign load_w            = in_valid && in_ready;
  assign out_ch.valid      = busy_r;
  assign out_ch.digit_char = ASCII_ZERO + {{(DIGIT_W-4){1'b0}}, digs_r[idx_r]};
  assign out_ch.last_digit = last_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load_w) begin
      busy_r <= 1'b1;
      idx_r  <= idx_nxt;
    end else if (busy_r && out_ch.ready) begin
      if (last_w) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_w) begin
      digs_r <= in_bcd[4*KEEP-1:0];
    end
  end

endmodule
`default_nettype wire

@@ src/binary_to_decimal_digits.sv @@
// Top level: binary to ASCII decimal digit converter.
//
// Each input item is a 31-bit unsigned integer; the block sends its decimal
// text as one result item per ASCII digit, most significant first, with no
// leading zeros, and last_digit set on the units digit. Zero gives a single
// '0'. Where a value has more than MAX_DIGITS digits only the low MAX_DIGITS
// are sent (leading zeros among those are kept). The conversion is a
// double-dabble pipeline of DD_STAGES register stages (four by default: three
// of eight shift steps and a last one of seven) and takes one new value every
// cycle while the serialiser does not hold it back. The digit serialiser after
// it sends one digit per cycle while the digit side is ready, and holds one
// item at a time until its units digit is taken. A value passes the stage
// registers in order and then the serialiser's digit registers. The
// serialiser takes the next item in the cycle its last digit is taken, so
// back-to-back items stream without a gap.
`default_nettype none
module binary_to_decimal_digits #(
  parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  b2d_in_if.sink     in_ch,
  b2d_out_if.source  out_ch
);
  import b2d_pkg::*;

  // Stage boundaries: index 0 is the input, DD_STAGES feeds the serialiser.
  logic [DD_STAGES:0] stg_valid;
  logic [DD_STAGES:0] stg_ready;
  dd_t                stg_data [DD_STAGES+1];

  assign stg_valid[0] = in_ch.valid;
  assign in_ch.ready  = stg_ready[0];
  assign stg_data[0]  = {{BCD_W{1'b0}}, in_ch.value};

  for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
    // last stage takes whatever bits remain
    localparam int STEPS = (g == DD_STAGES - 1) ? VALUE_W - (DD_STAGES - 1) * DD_STEPS
                                                : DD_STEPS;
    b2d_dd_stage #(
      .STEPS(STEPS)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_data   (stg_data[g]),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_data  (stg_data[g+1])
    );
  end

  // Serialiser holds the BCD digits and walks them down to the units digit.
  b2d_ser #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (stg_valid[DD_STAGES]),
    .in_ready (stg_ready[DD_STAGES]),
    .in_bcd   (stg_data[DD_STAGES].bcd),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

@@ tb/b2d_digit_checker.sv @@
// Checker: works out the expected digit text of each accepted value and compares the digit stream.
module b2d_digit_checker #(
  parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [b2d_pkg::VALUE_W-1:0] in_value,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [b2d_pkg::DIGIT_W-1:0] out_digit_char,
  input  logic                        out_last_digit,
  output int                          fail_count,
  output int                          digits_pending,
  output int                          digits_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import b2d_pkg::*;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit_char;
    logic               last_digit;
  } digit_t;

  digit_t expected_digits[$];
  int     fails   = 0;
  int     checked = 0;

  // Decimal text of one value, most significant digit first, appended to the
  // expected stream. Only the low MAX_DIGITS digits survive on wide values.
  function automatic void push_decimal_text(input logic [VALUE_W-1:0] value);
    logic [3:0]         units_first[$];
    logic [VALUE_W-1:0] rest;
    digit_t             d;
    rest = value;
    if (rest == '0) units_first.push_back(4'd0);
    while (rest != '0 && units_first.size() < MAX_DIGITS) begin
      units_first.push_back(4'(rest % 10));
      rest = VALUE_W'(rest / 10);
    end
    for (int k = units_first.size() - 1; k >= 0; k--) begin
      d.digit_char = ASCII_ZERO + DIGIT_W'(units_first[k]);
      d.last_digit = (k == 0);
      expected_digits.push_back(d);
    end
  endfunction

  // Results are matched before new values are queued: a value taken at this
  // edge cannot have produced a digit yet.
  always @(posedge clk) begin
    digit_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          $error("unexpected digit item: digit_char %0d, last_digit %0b",
                 out_digit_char, out_last_digit);
          fails++;
        end else begin
          want = expected_digits.pop_front();
          if (out_digit_char !== want.digit_char) begin
            $error("digit_char: expected %0d, actual %0d", want.digit_char, out_digit_char);
            fails++;
          end
          if (out_last_digit !== want.last_digit) begin
            $error("last_digit: expected %0b, actual %0b", want.last_digit, out_last_digit);
            fails++;
          end
          checked++;
        end
      end
      if (in_valid && in_ready) push_decimal_text(in_value);
    end
    fail_count     <= fails;
    digits_pending <= expected_digits.size();
    digits_checked <= checked;
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench top: clock, reset, value stimulus, digit back-pressure and the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b2d_pkg::*;

  localparam int RANDOM_ITEMS  = 480;
  localparam int CALM_ITEMS    = 60;      // tail of the run with no idling on either side
  localparam int PHASE_ITEMS   = 40;      // idle density is redrawn this often
  localparam int SETTLE_CYCLES = 16;      // pipeline latency plus a margin
  localparam int CYCLE_LIMIT   = 200000;  // run limit for the watchdog
  localparam longint VALUE_MAX = (64'd1 << VALUE_W) - 1;

  // Hand-picked values: zero, the single digit extremes, the digit count
  // boundaries at 10, 100, 10^6 and 10^9, the widest value, zeros in the
  // middle of a number and alternating bit patterns.
  localparam int NUM_DIRECTED = 24;
  localparam logic [VALUE_W-1:0] DIRECTED[NUM_DIRECTED] = '{
    31'd0,          31'd1,          31'd9,          31'd10,
    31'd11,         31'd99,         31'd100,        31'd101,
    31'd999999,     31'd1000000,    31'd999999999,  31'd1000000000,
    31'd1000000001, 31'd1999999999, 31'd2000000000, 31'd2147483646,
    31'd2147483647, 31'd1073741824, 31'd1431655765, 31'd715827882,
    31'd123456789,  31'd0,          31'd7,          31'd2147483647
  };

  logic clk;
  logic rst_n;

  b2d_in_if  in_ch ();
  b2d_out_if out_ch ();

  int         fail_count;
  int         digits_pending;
  int         digits_checked;
  int         cycles;
  int         sent      = 0;
  int         idle_pct  = 30;   // chance in percent of an idle burst per decision
  bit         calm      = 1'b0; // set for the tail: no gaps, no stalls
  bit [10:1]  lengths_hit = '0; // digit counts that the stimulus reached
  longint     pow10[11];

  binary_to_decimal_digits #(
    .MAX_DIGITS(MAX_DIGITS_DEF)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  b2d_digit_checker #(
    .MAX_DIGITS(MAX_DIGITS_DEF)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_value       (in_ch.value),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_digit_char (out_ch.digit_char),
    .out_last_digit (out_ch.last_digit),
    .fail_count     (fail_count),
    .digits_pending (digits_pending),
    .digits_checked (digits_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("watchdog: run did not complete within %0d cycles", CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Digit side back-pressure: stretches of ready or stall, each picked at random
  // and of random length. One assignment per edge, so no NBA ordering issue.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(99) < idle_pct) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Offers one value; may first drop valid for an idle burst of random length.
  // Returns at the edge where the value is taken. Valid stays high for a
  // following item, so it is never lowered and raised in one step.
  task automatic send_value(input logic [VALUE_W-1:0] value);
    int n;
    n = 1;
    for (longint p = 10; p <= value; p *= 10) n++;
    if (!calm && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    lengths_hit[n] = 1'b1;
    sent++;
  endtask

  initial begin
    logic [VALUE_W-1:0] value;
    longint             lo;
    longint             hi;
    int                 pick;
    int                 n;
    int                 b;

    pow10[0] = 1;
    for (int k = 1; k <= 10; k++) pow10[k] = pow10[k-1] * 10;

    // Synchronous reset; every input known from time zero.
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_value(DIRECTED[i]);

    // Random part. Most values are drawn per digit count so that short and
    // long numbers appear alike; the rest are raw 31-bit words, values just
    // around a power of ten, and single-bit or low-ones patterns.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0) begin
        case ($urandom_range(2))
          0:       idle_pct = 0;
          1:       idle_pct = 20;
          default: idle_pct = 50;
        endcase
      end
      calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
      pick = $urandom_range(99);
      if (pick < 65) begin
        n  = $urandom_range(1, 10);
        lo = (n == 1) ? 0 : pow10[n-1];
        hi = pow10[n] - 1;
        if (hi > VALUE_MAX) hi = VALUE_MAX;
        value = VALUE_W'(lo + $urandom_range(0, 32'(hi - lo)));
      end else if (pick < 85) begin
        value = VALUE_W'($urandom);
      end else if (pick < 95) begin
        // one below, at, or one above a power of ten
        value = VALUE_W'(pow10[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1);
      end else begin
        b = $urandom_range(0, VALUE_W - 1);
        value = $urandom_range(1) ? (VALUE_W'(1) << b)
                                  : ((VALUE_W'(1) << b) - VALUE_W'(1));
      end
      send_value(value);
    end
    in_ch.valid <= 1'b0;

    // Let the checker's counts catch up with the last edge, drain, then settle.
    @(posedge clk);
    while (digits_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d values converted (%0d hand-picked), %0d digit items checked",
             sent, NUM_DIRECTED, digits_checked);
    $display("digit counts reached (10 down to 1): %b", lengths_hit);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
